>>> hw/rtl/tae_pkg.sv
package tae_pkg;

   // axis codes
   localparam logic [1:0] AXIS_X   = 2'd0;
   localparam logic [1:0] AXIS_Y   = 2'd1;
   localparam logic [1:0] AXIS_Z   = 2'd2;
   localparam logic [1:0] AXIS_BAD = 2'd3;

   // datapath widths and scaling
   localparam int GAIN_BITS  = 30;
   localparam int GUARD_BITS = 16;
   localparam int AW         = 50;  // pair member with guard bits
   localparam int ZW         = 33;  // residual angle
   localparam int ATAN_W     = 30;
   localparam int TABLE_LEN  = 32;

   // micro-rotation angle steps, binary angle units
   localparam logic [ATAN_W-1:0] ATAN_STEP [TABLE_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81,
      30'd41,        30'd20,        30'd10,        30'd5,
      30'd3,         30'd1,         30'd1,         30'd0
   };

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } vec_type;

   // inverse cordic gain in q2.30, evaluated at elaboration
   function automatic logic [31:0] gain_inverse(input int steps);
      logic [63:0] g2;
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] num;
      logic [63:0] quo;
      logic [64:0] rem;
      int          i;
      g2 = 64'd1 << 60;
      for (i = 0; i < steps; i++) begin
         g2 = g2 + (g2 >> (2 * i));
      end
      // integer square root
      x     = g2;
      res   = 64'd0;
      bit_v = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
         if (bit_v > x) begin
            bit_v = bit_v >> 2;
         end
      end
      for (i = 0; i < 32; i++) begin
         if (bit_v != 64'd0) begin
            if (x >= res + bit_v) begin
               x   = x - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      if (res == 64'd0) begin
         res = 64'd1;
      end
      // rounded long division
      num = (64'd1 << 60) + (res >> 1);
      rem = 65'd0;
      quo = 64'd0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, res}) begin
            rem    = rem - {1'b0, res};
            quo[i] = 1'b1;
         end
      end
      return quo[31:0];
   endfunction

endpackage

>>> hw/rtl/tae_micro_stage.sv
module tae_micro_stage #(
   parameter int STEP = 0,
   parameter int CW   = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [tae_pkg::AW-1:0]     in_a,
   input  logic signed [tae_pkg::AW-1:0]     in_b,
   input  logic signed [tae_pkg::ZW-1:0]     in_z,
   input  logic [CW-1:0]                     in_carry,
   output logic                              out_valid,
   output logic signed [tae_pkg::AW-1:0]     out_a,
   output logic signed [tae_pkg::AW-1:0]     out_b,
   output logic signed [tae_pkg::ZW-1:0]     out_z,
   output logic [CW-1:0]                     out_carry
);

   localparam int AW = tae_pkg::AW;
   localparam int ZW = tae_pkg::ZW;
   localparam logic signed [ZW-1:0] ANGLE_STEP =
      $signed({{(ZW - tae_pkg::ATAN_W){1'b0}}, tae_pkg::ATAN_STEP[STEP]});

   logic                 valid_ff;
   logic signed [AW-1:0] a_ff, a_in;
   logic signed [AW-1:0] b_ff, b_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [CW-1:0]        carry_ff;
   logic signed [AW-1:0] da;
   logic signed [AW-1:0] db;

   // one micro-rotation, direction from residual sign
   always_comb begin
      da = in_b >>> STEP;
      db = in_a >>> STEP;
      if (!in_z[ZW-1]) begin
         a_in = in_a - da;
         b_in = in_b + db;
         z_in = in_z - ANGLE_STEP;
      end else begin
         a_in = in_a + da;
         b_in = in_b - db;
         z_in = in_z + ANGLE_STEP;
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         z_ff     <= z_in;
         carry_ff <= in_carry;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_z     = z_ff;
   assign out_carry = carry_ff;

endmodule

>>> hw/rtl/tae_rotation.sv
module tae_rotation #(
   parameter int CORDIC_STEPS = 24,
   parameter int SIDE_W       = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  tae_pkg::vec_type     in_vec,
   input  logic [1:0]           in_axis,
   input  logic signed [31:0]   in_angle,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output tae_pkg::vec_type     out_vec,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int AW    = tae_pkg::AW;
   localparam int ZW    = tae_pkg::ZW;
   localparam int GB    = tae_pkg::GUARD_BITS;
   localparam int SHIFT = tae_pkg::GAIN_BITS - tae_pkg::GUARD_BITS;
   localparam int RW    = AW - GB;
   localparam int CW    = 32 + 2 + SIDE_W;
   localparam logic signed [31:0]    GAIN_K    = tae_pkg::gain_inverse(CORDIC_STEPS);
   localparam logic signed [63:0]    MUL_HALF  = 64'sd1 <<< (SHIFT - 1);
   localparam logic signed [AW-1:0]  FIN_HALF  = AW'(64'd1 << (GB - 1));
   localparam logic signed [31:0]    QUARTER   = 32'sd1073741824;
   localparam logic signed [ZW-1:0]  HALF_TURN = 33'sh0_8000_0000;

   function automatic logic [31:0] sat32(input logic [RW-1:0] v);
      logic [RW-32:0] hi;
      hi = v[RW-1:31];
      if (&hi || !(|hi)) begin
         return v[31:0];
      end else if (v[RW-1]) begin
         return 32'h8000_0000;
      end else begin
         return 32'h7FFF_FFFF;
      end
   endfunction

   // select the turned pair and prescale by the gain inverse
   logic signed [31:0] pa;
   logic signed [31:0] pb;
   logic [31:0]        pc;
   logic               mul_valid_ff;
   logic signed [63:0] mul_a_ff, mul_a_in;
   logic signed [63:0] mul_b_ff, mul_b_in;
   logic signed [31:0] mul_z_ff;
   logic [CW-1:0]      mul_carry_ff, mul_carry_in;

   always_comb begin
      unique case (in_axis)
         tae_pkg::AXIS_X: begin
            pa = $signed(in_vec.y);
            pb = $signed(in_vec.z);
            pc = in_vec.x;
         end
         tae_pkg::AXIS_Y: begin
            pa = $signed(in_vec.z);
            pb = $signed(in_vec.x);
            pc = in_vec.y;
         end
         default: begin
            pa = $signed(in_vec.x);
            pb = $signed(in_vec.y);
            pc = in_vec.z;
         end
      endcase
      mul_a_in     = pa * GAIN_K;
      mul_b_in     = pb * GAIN_K;
      mul_carry_in = {pc, in_axis, in_side};
   end

   // round the product down to guard precision, fold the angle
   logic signed [63:0]   sum_a;
   logic signed [63:0]   sum_b;
   logic signed [ZW-1:0] z_ext;
   logic                 rnd_valid_ff;
   logic signed [AW-1:0] rnd_a_ff, rnd_a_in;
   logic signed [AW-1:0] rnd_b_ff, rnd_b_in;
   logic signed [ZW-1:0] rnd_z_ff, rnd_z_in;
   logic                 rnd_flip_ff, rnd_flip_in;
   logic [CW-1:0]        rnd_carry_ff;

   always_comb begin
      sum_a       = mul_a_ff + MUL_HALF;
      sum_b       = mul_b_ff + MUL_HALF;
      rnd_a_in    = sum_a[SHIFT +: AW];
      rnd_b_in    = sum_b[SHIFT +: AW];
      z_ext       = {mul_z_ff[31], mul_z_ff};
      rnd_flip_in = (mul_z_ff > QUARTER) || (mul_z_ff < -QUARTER);
      if (!rnd_flip_in) begin
         rnd_z_in = z_ext;
      end else if (mul_z_ff > 32'sd0) begin
         rnd_z_in = z_ext - HALF_TURN;
      end else begin
         rnd_z_in = z_ext + HALF_TURN;
      end
   end

   // negate the pair for the far half plane
   logic                 neg_valid_ff;
   logic signed [AW-1:0] neg_a_ff, neg_a_in;
   logic signed [AW-1:0] neg_b_ff, neg_b_in;
   logic signed [ZW-1:0] neg_z_ff;
   logic [CW-1:0]        neg_carry_ff;

   always_comb begin
      neg_a_in = rnd_flip_ff ? -rnd_a_ff : rnd_a_ff;
      neg_b_in = rnd_flip_ff ? -rnd_b_ff : rnd_b_ff;
   end

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rnd_valid_ff <= 1'b0;
         neg_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= in_valid;
         rnd_valid_ff <= mul_valid_ff;
         neg_valid_ff <= rnd_valid_ff;
      end
   end

   // payload of the front stages
   always_ff @(posedge clock) begin
      if (en) begin
         mul_a_ff     <= mul_a_in;
         mul_b_ff     <= mul_b_in;
         mul_z_ff     <= in_angle;
         mul_carry_ff <= mul_carry_in;
         rnd_a_ff     <= rnd_a_in;
         rnd_b_ff     <= rnd_b_in;
         rnd_z_ff     <= rnd_z_in;
         rnd_flip_ff  <= rnd_flip_in;
         rnd_carry_ff <= mul_carry_ff;
         neg_a_ff     <= neg_a_in;
         neg_b_ff     <= neg_b_in;
         neg_z_ff     <= rnd_z_ff;
         neg_carry_ff <= rnd_carry_ff;
      end
   end

   // micro-rotation chain, one stage per step
   logic                 it_valid [CORDIC_STEPS+1];
   logic signed [AW-1:0] it_a     [CORDIC_STEPS+1];
   logic signed [AW-1:0] it_b     [CORDIC_STEPS+1];
   logic signed [ZW-1:0] it_z     [CORDIC_STEPS+1];
   logic [CW-1:0]        it_carry [CORDIC_STEPS+1];

   assign it_valid[0] = neg_valid_ff;
   assign it_a[0]     = neg_a_ff;
   assign it_b[0]     = neg_b_ff;
   assign it_z[0]     = neg_z_ff;
   assign it_carry[0] = neg_carry_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      tae_micro_stage #(
         .STEP (k),
         .CW   (CW)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (it_valid[k]),
         .in_a      (it_a[k]),
         .in_b      (it_b[k]),
         .in_z      (it_z[k]),
         .in_carry  (it_carry[k]),
         .out_valid (it_valid[k+1]),
         .out_a     (it_a[k+1]),
         .out_b     (it_b[k+1]),
         .out_z     (it_z[k+1]),
         .out_carry (it_carry[k+1])
      );
   end

   // drop guard bits, saturate, put the pair back in place
   logic signed [AW-1:0] fin_sum_a;
   logic signed [AW-1:0] fin_sum_b;
   logic [31:0]          sat_a;
   logic [31:0]          sat_b;
   logic [31:0]          fin_c;
   logic [1:0]           fin_axis;
   logic                 fin_valid_ff;
   tae_pkg::vec_type     fin_vec_ff, fin_vec_in;
   logic [SIDE_W-1:0]    fin_side_ff;

   always_comb begin
      fin_sum_a = it_a[CORDIC_STEPS] + FIN_HALF;
      fin_sum_b = it_b[CORDIC_STEPS] + FIN_HALF;
      sat_a     = sat32(fin_sum_a[AW-1:GB]);
      sat_b     = sat32(fin_sum_b[AW-1:GB]);
      fin_c     = it_carry[CORDIC_STEPS][CW-1:SIDE_W+2];
      fin_axis  = it_carry[CORDIC_STEPS][SIDE_W+1:SIDE_W];
      unique case (fin_axis)
         tae_pkg::AXIS_X: begin
            fin_vec_in.x = fin_c;
            fin_vec_in.y = sat_a;
            fin_vec_in.z = sat_b;
         end
         tae_pkg::AXIS_Y: begin
            fin_vec_in.x = sat_b;
            fin_vec_in.y = fin_c;
            fin_vec_in.z = sat_a;
         end
         default: begin
            fin_vec_in.x = sat_a;
            fin_vec_in.y = sat_b;
            fin_vec_in.z = fin_c;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= it_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_vec_ff  <= fin_vec_in;
         fin_side_ff <= it_carry[CORDIC_STEPS][SIDE_W-1:0];
      end
   end

   assign out_valid = fin_valid_ff;
   assign out_vec   = fin_vec_ff;
   assign out_side  = fin_side_ff;

endmodule

>>> hw/rtl/two_axis_euler_rotation.sv
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_in_x/y/z, req_first_*, req_second_*
// rsp      out        rsp_valid/rsp_ready  rsp_out_x/y/z, rsp_bad_axis
//
// one item per cycle sustained while the skid is empty; results pass through
// two rotation pipelines of multiply, round, fold, one stage per micro-rotation
// and a saturate stage, followed by the output register.
// reset is synchronous and clears only valid bits of the stages, the output and the skid.
// the pipeline moves as one; a stalled result parks in a one-entry skid, and
// req_ready drops for as long as that skid holds an item.
module two_axis_euler_rotation #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [31:0] req_in_z,
   input  logic signed [31:0] req_first_angle,
   input  logic [1:0]         req_first_axis,
   input  logic signed [31:0] req_second_angle,
   input  logic [1:0]         req_second_axis,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_bad_axis
);

   localparam int SIDE1_W = 32 + 2 + 1;

   logic             en;
   logic             req_bad;
   tae_pkg::vec_type req_vec;
   logic             rot1_valid;
   tae_pkg::vec_type rot1_vec;
   logic [SIDE1_W-1:0] rot1_side;
   logic             rot2_valid;
   tae_pkg::vec_type rot2_vec;
   logic             rot2_bad;
   logic             push;
   tae_pkg::vec_type res_vec;

   // output register and skid
   logic             rsp_valid_ff, rsp_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   tae_pkg::vec_type rsp_vec_ff, rsp_vec_in;
   logic             rsp_bad_ff, rsp_bad_in;
   tae_pkg::vec_type skid_vec_ff, skid_vec_in;
   logic             skid_bad_ff, skid_bad_in;

   // pipeline advances unless the skid is occupied
   assign en        = !skid_valid_ff;
   assign req_ready = en;

   assign req_bad   = (req_first_axis == tae_pkg::AXIS_BAD) ||
                      (req_second_axis == tae_pkg::AXIS_BAD);
   assign req_vec.x = req_in_x;
   assign req_vec.y = req_in_y;
   assign req_vec.z = req_in_z;

   // first rotation carries the second angle and axis along
   tae_rotation #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .SIDE_W       (SIDE1_W)
   ) u_rot1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_vec    (req_vec),
      .in_axis   (req_first_axis),
      .in_angle  (req_first_angle),
      .in_side   ({req_second_angle, req_second_axis, req_bad}),
      .out_valid (rot1_valid),
      .out_vec   (rot1_vec),
      .out_side  (rot1_side)
   );

   tae_rotation #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .SIDE_W       (1)
   ) u_rot2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rot1_valid),
      .in_vec    (rot1_vec),
      .in_axis   (rot1_side[2:1]),
      .in_angle  ($signed(rot1_side[SIDE1_W-1:3])),
      .in_side   (rot1_side[0]),
      .out_valid (rot2_valid),
      .out_vec   (rot2_vec),
      .out_side  (rot2_bad)
   );

   // invalid axis gives a zero vector
   assign res_vec = rot2_bad ? '0 : rot2_vec;
   assign push    = en && rot2_valid;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_vec_in    = rsp_vec_ff;
      rsp_bad_in    = rsp_bad_ff;
      skid_vec_in   = skid_vec_ff;
      skid_bad_in   = skid_bad_ff;
      if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_vec_in    = skid_vec_ff;
            rsp_bad_in    = skid_bad_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push;
            rsp_vec_in   = res_vec;
            rsp_bad_in   = rot2_bad;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_vec_in   = res_vec;
         skid_bad_in   = rot2_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_vec_ff  <= rsp_vec_in;
      rsp_bad_ff  <= rsp_bad_in;
      skid_vec_ff <= skid_vec_in;
      skid_bad_ff <= skid_bad_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = $signed(rsp_vec_ff.x);
   assign rsp_out_y    = $signed(rsp_vec_ff.y);
   assign rsp_out_z    = $signed(rsp_vec_ff.z);
   assign rsp_bad_axis = rsp_bad_ff;

`ifndef ASSERT_OFF
   // skid only holds an item behind a waiting output
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while the output register is empty");

   // skid fills only when the output was stalled
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid filled without a stalled output");

   // parked item is not dropped while the output stays stalled
   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("skid item lost during stall");

   // flagged items carry a zero vector
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |->
         (rsp_vec_ff.x == 32'd0 && rsp_vec_ff.y == 32'd0 && rsp_vec_ff.z == 32'd0))
      else $error("bad axis item with nonzero vector");
`endif

endmodule

>>> sim/two_axis_euler_rotation_test.sv
`timescale 1ns / 100ps

module two_axis_euler_rotation_test;

   localparam int CORDIC_STEPS = 24;
   localparam int PIPE_LATENCY = 2 * (CORDIC_STEPS + 4) + 1;
   localparam int PRODUCT_SHIFT = 14;
   localparam int GUARD_SHIFT = 16;
   localparam longint QUARTER_TURN = 64'sh4000_0000;
   localparam longint HALF_TURN = 64'sh8000_0000;
   localparam longint WORD_MAX = 64'sh7FFF_FFFF;
   localparam longint WORD_MIN = -64'sh8000_0000;

   // micro-rotation angle steps in binary angle units
   localparam longint ARCTAN_UNITS [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   typedef struct packed {
      tae_pkg::vec_type v;
      logic [31:0]      first_angle;
      logic [1:0]       first_axis;
      logic [31:0]      second_angle;
      logic [1:0]       second_axis;
   } rotation_item_type;

   typedef struct packed {
      tae_pkg::vec_type v;
      logic             bad_axis;
   } rotation_result_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_in_x;
   logic signed [31:0] req_in_y;
   logic signed [31:0] req_in_z;
   logic signed [31:0] req_first_angle;
   logic [1:0]         req_first_axis;
   logic signed [31:0] req_second_angle;
   logic [1:0]         req_second_axis;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_bad_axis;

   rotation_result_type rotated_q [$];
   int                  items_sent = 0;
   int                  bad_items = 0;
   int                  results_checked = 0;
   int                  failure_count = 0;
   bit                  send_idle_on = 1'b1;
   bit                  reply_idle_on = 1'b1;
   int                  hold_request = 0;

   two_axis_euler_rotation #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_x(req_in_x),
      .req_in_y(req_in_y),
      .req_in_z(req_in_z),
      .req_first_angle(req_first_angle),
      .req_first_axis(req_first_axis),
      .req_second_angle(req_second_angle),
      .req_second_axis(req_second_axis),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_bad_axis(rsp_bad_axis)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // inverse cordic gain in q2.30, square root by bisection
   function automatic longint cordic_gain_q30(input int steps);
      longint unsigned g2;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      int              i;
      g2 = 64'd1 << 60;
      for (i = 0; i < steps; i++) begin
         g2 = g2 + (g2 >> (2 * i));
      end
      lo = 0;
      hi = 64'hFFFF_FFFF;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= g2) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      if (lo == 0) begin
         lo = 1;
      end
      return longint'(((64'd1 << 60) + (lo >> 1)) / lo);
   endfunction

   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_word(input longint v);
      if (v > WORD_MAX) begin
         return WORD_MAX;
      end
      if (v < WORD_MIN) begin
         return WORD_MIN;
      end
      return v;
   endfunction

   // one gain-compensated rotation of a coordinate pair
   function automatic void turn_pair(inout longint lead, inout longint trail,
                                     input longint angle);
      longint k;
      longint a;
      longint b;
      longint z;
      longint da;
      longint db;
      int     i;
      k = cordic_gain_q30(CORDIC_STEPS);
      a = round_shift(lead * k, PRODUCT_SHIFT);
      b = round_shift(trail * k, PRODUCT_SHIFT);
      z = angle;
      // fold angles beyond a quarter turn by half a turn
      if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
         a = -a;
         b = -b;
         z = (z > 0) ? z - HALF_TURN : z + HALF_TURN;
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
         da = b >>> i;
         db = a >>> i;
         if (z >= 0) begin
            a = a - da;
            b = b + db;
            z = z - ARCTAN_UNITS[i];
         end else begin
            a = a + da;
            b = b - db;
            z = z + ARCTAN_UNITS[i];
         end
      end
      lead = clamp_word(round_shift(a, GUARD_SHIFT));
      trail = clamp_word(round_shift(b, GUARD_SHIFT));
   endfunction

   function automatic void turn_about(inout longint vx, inout longint vy,
                                      inout longint vz, input logic [1:0] axis,
                                      input logic [31:0] angle);
      longint ang;
      ang = longint'($signed(angle));
      case (axis)
         tae_pkg::AXIS_X: turn_pair(vy, vz, ang);
         tae_pkg::AXIS_Y: turn_pair(vz, vx, ang);
         default: turn_pair(vx, vy, ang);
      endcase
   endfunction

   function automatic rotation_result_type euler_rotate(input rotation_item_type r);
      rotation_result_type res;
      longint              vx;
      longint              vy;
      longint              vz;
      res = '0;
      if (r.first_axis == tae_pkg::AXIS_BAD || r.second_axis == tae_pkg::AXIS_BAD) begin
         res.bad_axis = 1'b1;
         return res;
      end
      vx = longint'($signed(r.v.x));
      vy = longint'($signed(r.v.y));
      vz = longint'($signed(r.v.z));
      turn_about(vx, vy, vz, r.first_axis, r.first_angle);
      turn_about(vx, vy, vz, r.second_axis, r.second_angle);
      res.v.x = 32'(vx);
      res.v.y = 32'(vy);
      res.v.z = 32'(vz);
      return res;
   endfunction

   function automatic rotation_item_type rotation_item(
      input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
      input logic [31:0] a1, input logic [1:0] ax1,
      input logic [31:0] a2, input logic [1:0] ax2);
      rotation_item_type r;
      r.v.x = x;
      r.v.y = y;
      r.v.z = z;
      r.first_angle = a1;
      r.first_axis = ax1;
      r.second_angle = a2;
      r.second_axis = ax2;
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] random_component();
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: w = 32'h7FFF_FFFF;
               1: w = 32'h8000_0000;
               2: w = 32'h0000_0000;
               3: w = 32'hFFFF_FFFF;
               default: w = 32'h0000_0001;
            endcase
         end
         1, 2, 3: w = $signed(w) >>> $urandom_range(8, 30);
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] random_angle();
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 6))
               0: w = 32'h4000_0000;
               1: w = 32'h4000_0001;
               2: w = 32'hC000_0000;
               3: w = 32'hBFFF_FFFF;
               4: w = 32'h8000_0000;
               5: w = 32'h7FFF_FFFF;
               default: w = 32'h0000_0000;
            endcase
         end
         // near the fold boundaries
         1: begin
            w = 32'h4000_0000 + $urandom_range(0, 64) - 32;
            if ($urandom_range(0, 1) == 1) begin
               w = -w;
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [1:0] random_axis();
      if ($urandom_range(0, 19) == 0) begin
         return tae_pkg::AXIS_BAD;
      end
      case ($urandom_range(0, 2))
         0: return tae_pkg::AXIS_X;
         1: return tae_pkg::AXIS_Y;
         default: return tae_pkg::AXIS_Z;
      endcase
   endfunction

   function automatic rotation_item_type random_item();
      return rotation_item(random_component(), random_component(), random_component(),
                           random_angle(), random_axis(), random_angle(), random_axis());
   endfunction

   // offer one item and hold it until accepted
   task automatic send_rotation(input rotation_item_type r);
      int gap;
      req_valid <= 1'b1;
      req_in_x <= r.v.x;
      req_in_y <= r.v.y;
      req_in_z <= r.v.z;
      req_first_angle <= r.first_angle;
      req_first_axis <= r.first_axis;
      req_second_angle <= r.second_angle;
      req_second_axis <= r.second_axis;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      rotated_q.push_back(euler_rotate(r));
      items_sent++;
      if (r.first_axis == tae_pkg::AXIS_BAD || r.second_axis == tae_pkg::AXIS_BAD) begin
         bad_items++;
      end
      gap = (send_idle_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (rotated_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // extremes of components and angles, fold boundaries, saturation
   task automatic test_directed_extremes();
      logic [31:0] pos;
      logic [31:0] neg;
      pos = 32'h7FFF_FFFF;
      neg = 32'h8000_0000;
      send_rotation(rotation_item('0, '0, '0, '0, tae_pkg::AXIS_X, '0, tae_pkg::AXIS_Y));
      send_rotation(rotation_item(pos, pos, pos, '0, tae_pkg::AXIS_Z, '0, tae_pkg::AXIS_Z));
      send_rotation(rotation_item(neg, neg, neg, '0, tae_pkg::AXIS_X, '0, tae_pkg::AXIS_Y));
      send_rotation(rotation_item(pos, pos, '0, 32'h2000_0000, tae_pkg::AXIS_Z,
                                  '0, tae_pkg::AXIS_Z));
      send_rotation(rotation_item(neg, neg, '0, 32'h2000_0000, tae_pkg::AXIS_Z,
                                  '0, tae_pkg::AXIS_X));
      send_rotation(rotation_item(pos, neg, pos, 32'h4000_0000, tae_pkg::AXIS_X,
                                  32'h4000_0001, tae_pkg::AXIS_Y));
      send_rotation(rotation_item(neg, pos, 32'h0001_0000, 32'hC000_0000, tae_pkg::AXIS_Y,
                                  32'hBFFF_FFFF, tae_pkg::AXIS_Z));
      send_rotation(rotation_item(32'h0001_0000, 32'hFFFF_0000, pos, 32'h8000_0000,
                                  tae_pkg::AXIS_Z, 32'h7FFF_FFFF, tae_pkg::AXIS_X));
      // every pair of valid axes
      for (int a1 = 0; a1 < 3; a1++) begin
         for (int a2 = 0; a2 < 3; a2++) begin
            send_rotation(rotation_item(random_component(), random_component(),
                                        random_component(), $urandom(), 2'(a1),
                                        $urandom(), 2'(a2)));
         end
      end
   endtask

   task automatic test_bad_axis_codes();
      send_rotation(rotation_item(32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000,
                                  32'h1000_0000, tae_pkg::AXIS_BAD, '0, tae_pkg::AXIS_X));
      send_rotation(rotation_item($urandom(), $urandom(), $urandom(), $urandom(),
                                  tae_pkg::AXIS_Z, $urandom(), tae_pkg::AXIS_BAD));
      send_rotation(rotation_item($urandom(), $urandom(), $urandom(), $urandom(),
                                  tae_pkg::AXIS_BAD, $urandom(), tae_pkg::AXIS_BAD));
      send_rotation(rotation_item('1, '1, '1, '1, tae_pkg::AXIS_BAD, '1, tae_pkg::AXIS_Y));
   endtask

   task automatic test_random_rotations(input int count);
      repeat (count) send_rotation(random_item());
   endtask

   // full rate on both sides
   task automatic test_back_to_back(input int count);
      send_idle_on = 1'b0;
      reply_idle_on = 1'b0;
      repeat (count) send_rotation(random_item());
      wait_all_results();
      send_idle_on = 1'b1;
      reply_idle_on = 1'b1;
   endtask

   // receiver holds off long enough to fill the pipeline and stall the input
   task automatic test_output_backpressure(input int count);
      send_idle_on = 1'b0;
      hold_request = 4 * PIPE_LATENCY;
      repeat (count) send_rotation(random_item());
      send_idle_on = 1'b1;
   endtask

   // result side readiness, with its own stall counter
   initial begin : reply_side
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (reply_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = idle_length() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin : result_check
      rotation_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rotated_q.size() == 0) begin
            failure_count++;
            if (failure_count <= 10) begin
               $display("unexpected result: x=%h y=%h z=%h bad=%b",
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_bad_axis);
            end
         end else begin
            want = rotated_q.pop_front();
            results_checked++;
            if (rsp_out_x !== want.v.x || rsp_out_y !== want.v.y ||
                rsp_out_z !== want.v.z || rsp_bad_axis !== want.bad_axis) begin
               failure_count++;
               if (failure_count <= 10) begin
                  $display("mismatch on result %0d: expected x=%h y=%h z=%h bad=%b",
                           results_checked, want.v.x, want.v.y, want.v.z, want.bad_axis);
                  $display("                        actual   x=%h y=%h z=%h bad=%b",
                           rsp_out_x, rsp_out_y, rsp_out_z, rsp_bad_axis);
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      req_first_angle = '0;
      req_first_axis = tae_pkg::AXIS_X;
      req_second_angle = '0;
      req_second_axis = tae_pkg::AXIS_X;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_bad_axis_codes();
      wait_all_results();
      test_random_rotations(450);
      wait_all_results();
      test_back_to_back(150);
      test_output_backpressure(120);
      test_random_rotations(300);
      wait_all_results();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (rotated_q.size() != 0) begin
         failure_count++;
         $display("%0d expected results never arrived", rotated_q.size());
      end
      $display("sent %0d items (%0d with an invalid axis code), checked %0d results",
               items_sent, bad_items, results_checked);
      $display("covered idle gaps on both sides, full rate, and a stalled output");
      if (failure_count == 0) begin
         $display("two_axis_euler_rotation_test OK");
      end else begin
         $display("two_axis_euler_rotation_test NOT OK");
      end
      $finish;
   end

   // run limit
   initial begin
      #(10_000_000);
      $display("timeout with %0d results outstanding", rotated_q.size());
      $display("two_axis_euler_rotation_test NOT OK");
      $finish;
   end

endmodule
